// ===== hdl/bprm_pkg.sv =====
// Package with register addresses, access codes and the gauge voltage table.
package bprm_pkg;

	localparam int GAUGE_SEGMENTS = 8;
	localparam int TABLE_SEGMENTS = 8;
	localparam int SEG_COUNT = (GAUGE_SEGMENTS < TABLE_SEGMENTS) ? GAUGE_SEGMENTS : TABLE_SEGMENTS;
	localparam int SEG_W = $clog2(TABLE_SEGMENTS);
	localparam int FRAC_BITS = 5;
	localparam int CNT_W = $clog2(FRAC_BITS);

	localparam logic [15:0] GAUGE_TABLE [0:TABLE_SEGMENTS] = '{
		16'd2684, 16'd2864, 16'd3064, 16'd3264, 16'd3444,
		16'd3644, 16'd3824, 16'd4024, 16'd4204
	};

	localparam logic [1:0] KIND_READ   = 2'd0;
	localparam logic [1:0] KIND_WRITE  = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;
	localparam logic [1:0] STATE_TERMINATED = 2'b11;

	localparam logic [7:0] VERSION_BYTE = 8'h02;
	localparam logic [7:0] LEVEL_FULL   = 8'hFF;

	localparam logic [7:0] ADDR_VERSION   = 8'h00;
	localparam logic [7:0] ADDR_APPLY     = 8'h02;
	localparam logic [7:0] ADDR_FAN       = 8'h04;
	localparam logic [7:0] ADDR_SHIP      = 8'h0B;
	localparam logic [7:0] ADDR_ICHG_L    = 8'h10;
	localparam logic [7:0] ADDR_ICHG_H    = 8'h11;
	localparam logic [7:0] ADDR_ITERM_L   = 8'h12;
	localparam logic [7:0] ADDR_ITERM_H   = 8'h13;
	localparam logic [7:0] ADDR_IPRE_L    = 8'h14;
	localparam logic [7:0] ADDR_IPRE_H    = 8'h15;
	localparam logic [7:0] ADDR_VCHG_L    = 8'h16;
	localparam logic [7:0] ADDR_VCHG_H    = 8'h17;
	localparam logic [7:0] ADDR_CHG_STATE = 8'h18;
	localparam logic [7:0] ADDR_LEVEL     = 8'h24;
	localparam logic [7:0] ADDR_VBAT_L    = 8'h26;
	localparam logic [7:0] ADDR_VBAT_H    = 8'h27;

endpackage

// ===== hdl/battery_pack_register_map.sv =====
// Battery pack register map: byte registers, status capture and serial charge gauge.
// The result is registered from ST_EXEC once the output is free; a gauge read that
// interpolates passes ST_DIV (a 5-step bit-serial divider yields the fraction one
// bit a cycle) and ST_FIN first. in_stall holds off new transactions until done.
// Reset: asynchronous on arst_n; settings, voltage and fan speed take their defaults.
module battery_pack_register_map (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  address,
	input  logic [7:0]  write_data,
	input  logic [15:0] batt_mv,
	input  logic [1:0]  charge_state,
	input  logic        console_powered,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        apply_now,
	output logic        ship_now,
	output logic        fan_update,
	output logic        fan_on,
	output logic [7:0]  fan_duty
);
	import bprm_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_DIV, ST_FIN} state_t;

	state_t state_q;
	logic [1:0]  kind_q;
	logic [7:0]  addr_q;
	logic [7:0]  data_q;
	logic [15:0] mv_in_q;
	logic [1:0]  cs_in_q;
	logic        pw_in_q;

	logic [15:0] ichg_q, iterm_q, ipre_q, vchg_q, vbat_q;
	logic [7:0]  fan_speed_q;
	logic [1:0]  chg_state_q;
	logic        powered_q;
	logic [7:0]  level_q;

	logic [SEG_W-1:0]     seg_q;
	logic [7:0]           den_q;
	logic [7:0]           rem_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [CNT_W-1:0]     cnt_q;

	logic out_valid_q;
	logic [7:0] read_data_q, fan_duty_q;
	logic apply_q, ship_q, fan_update_q, fan_on_q;

	logic             out_free;
	logic             out_load;
	logic             seg_found;
	logic [SEG_W-1:0] seg_idx;
	logic [15:0]      seg_lo, seg_hi;
	logic [15:0]      seg_diff, seg_span;
	logic             need_div;
	logic [7:0]       r_read, r_duty;
	logic             r_apply, r_ship, r_fupd, r_fon;
	logic [8:0]       rem_dbl;
	logic             rem_ge;

	assign out_free = !out_valid_q || !out_stall;
	assign out_load = out_free && ((state_q == ST_EXEC && !need_div) || state_q == ST_FIN);
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		seg_found = 1'b0;
		seg_idx = '0;
		for (int i = SEG_COUNT - 1; i >= 0; i--) begin
			if (vbat_q >= GAUGE_TABLE[i] && vbat_q < GAUGE_TABLE[i+1]) begin
				seg_found = 1'b1;
				seg_idx = SEG_W'(i);
			end
		end
		seg_lo = GAUGE_TABLE[{1'b0, seg_idx}];
		seg_hi = GAUGE_TABLE[{1'b0, seg_idx} + 4'd1];
		seg_diff = vbat_q - seg_lo;
		seg_span = seg_hi - seg_lo;
	end

	assign rem_dbl = {rem_q, 1'b0};
	assign rem_ge = rem_dbl >= {1'b0, den_q};

	always_comb begin
		r_read = '0;
		r_apply = 1'b0;
		r_ship = 1'b0;
		r_fupd = 1'b0;
		r_fon = 1'b0;
		r_duty = '0;
		need_div = 1'b0;
		if (kind_q == KIND_READ || kind_q == KIND_WRITE) begin
			if (addr_q == ADDR_APPLY) begin
				r_apply = 1'b1;
				r_fupd = 1'b1;
				r_fon = powered_q && (fan_speed_q != 8'd0);
				r_duty = r_fon ? fan_speed_q : 8'd0;
			end else if (addr_q == ADDR_SHIP) begin
				r_ship = 1'b1;
			end else if (kind_q == KIND_READ) begin
				unique case (addr_q)
					ADDR_VERSION:   r_read = VERSION_BYTE;
					ADDR_FAN:       r_read = fan_speed_q;
					ADDR_ICHG_L:    r_read = ichg_q[7:0];
					ADDR_ICHG_H:    r_read = ichg_q[15:8];
					ADDR_ITERM_L:   r_read = iterm_q[7:0];
					ADDR_ITERM_H:   r_read = iterm_q[15:8];
					ADDR_IPRE_L:    r_read = ipre_q[7:0];
					ADDR_IPRE_H:    r_read = ipre_q[15:8];
					ADDR_VCHG_L:    r_read = vchg_q[7:0];
					ADDR_VCHG_H:    r_read = vchg_q[15:8];
					ADDR_CHG_STATE: r_read = {6'd0, chg_state_q};
					ADDR_LEVEL: begin
						if (chg_state_q == STATE_TERMINATED) begin
							r_read = LEVEL_FULL;
						end else begin
							r_read = level_q;
							need_div = seg_found;
						end
					end
					ADDR_VBAT_L:    r_read = vbat_q[7:0];
					ADDR_VBAT_H:    r_read = vbat_q[15:8];
					default:        r_read = '0;
				endcase
			end else if (addr_q == ADDR_FAN) begin
				r_fupd = 1'b1;
				r_fon = (data_q != 8'd0);
				r_duty = data_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q <= '0;
			addr_q <= '0;
			data_q <= '0;
			mv_in_q <= '0;
			cs_in_q <= '0;
			pw_in_q <= 1'b0;
			ichg_q <= 16'd4096;
			iterm_q <= 16'd256;
			ipre_q <= 16'd128;
			vchg_q <= 16'd4208;
			fan_speed_q <= 8'd255;
			vbat_q <= 16'd3700;
			chg_state_q <= '0;
			powered_q <= 1'b0;
			level_q <= '0;
			seg_q <= '0;
			den_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			read_data_q <= '0;
			apply_q <= 1'b0;
			ship_q <= 1'b0;
			fan_update_q <= 1'b0;
			fan_on_q <= 1'b0;
			fan_duty_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						kind_q <= kind;
						addr_q <= address;
						data_q <= write_data;
						mv_in_q <= batt_mv;
						cs_in_q <= charge_state;
						pw_in_q <= console_powered;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (need_div) begin
						seg_q <= seg_idx;
						den_q <= seg_span[7:0];
						rem_q <= seg_diff[7:0];
						quo_q <= '0;
						cnt_q <= '0;
						state_q <= ST_DIV;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						read_data_q <= r_read;
						apply_q <= r_apply;
						ship_q <= r_ship;
						fan_update_q <= r_fupd;
						fan_on_q <= r_fon;
						fan_duty_q <= r_fon ? r_duty : 8'd0;
						state_q <= ST_IDLE;
						if (kind_q == KIND_STATUS) begin
							vbat_q <= mv_in_q;
							chg_state_q <= cs_in_q;
							powered_q <= pw_in_q;
						end
						if (kind_q == KIND_READ && addr_q == ADDR_LEVEL &&
						    chg_state_q == STATE_TERMINATED) begin
							level_q <= LEVEL_FULL;
						end
						if (kind_q == KIND_WRITE) begin
							unique case (addr_q)
								ADDR_FAN:     fan_speed_q <= data_q;
								ADDR_ICHG_L:  ichg_q[7:0] <= data_q;
								ADDR_ICHG_H:  ichg_q[15:8] <= data_q;
								ADDR_ITERM_L: iterm_q[7:0] <= data_q;
								ADDR_ITERM_H: iterm_q[15:8] <= data_q;
								ADDR_IPRE_L:  ipre_q[7:0] <= data_q;
								ADDR_IPRE_H:  ipre_q[15:8] <= data_q;
								ADDR_VCHG_L:  vchg_q[7:0] <= data_q;
								ADDR_VCHG_H:  vchg_q[15:8] <= data_q;
								default: ;
							endcase
						end
					end
				end
				ST_DIV: begin
					rem_q <= rem_ge ? 8'(rem_dbl - {1'b0, den_q}) : rem_dbl[7:0];
					quo_q <= {quo_q[FRAC_BITS-2:0], rem_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(FRAC_BITS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						level_q <= {seg_q, quo_q};
						out_valid_q <= 1'b1;
						read_data_q <= {seg_q, quo_q};
						apply_q <= 1'b0;
						ship_q <= 1'b0;
						fan_update_q <= 1'b0;
						fan_on_q <= 1'b0;
						fan_duty_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign apply_now = apply_q;
	assign ship_now = ship_q;
	assign fan_update = fan_update_q;
	assign fan_on = fan_on_q;
	assign fan_duty = fan_duty_q;

endmodule
